FILE: hdl/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
// No dependencies; all files of the block but bbc_if import this package.
`timescale 1ns / 1ps

package bbc_pkg;

  // Stack capacity in entries, and the widths that follow from it.
  localparam int STACK_DEPTH = 64;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes of the brackets.
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Kind codes kept on the stack.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_t;

  // One classified character, as handed from the front to the back.
  typedef struct packed {
    op_t   op;
    kind_t kind;
    logic  last;
  } cmd_t;

endpackage

FILE: hdl/bbc_if.sv
// Valid/ready channel interfaces of the bracket balance checker.
// Standalone; the character channel and the verdict channel.
`timescale 1ns / 1ps

interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface bbc_out_if;
  logic valid;
  logic ready;
  logic balanced;
  logic overflow;

  modport source (output valid, output balanced, output overflow, input ready);
  modport sink   (input valid, input balanced, input overflow, output ready);
endinterface

FILE: hdl/bbc_front.sv
// Front end: accepts character words and turns each into a stack command.
// Depends on bbc_pkg and bbc_in_if.
`timescale 1ns / 1ps

module bbc_front
  import bbc_pkg::*;
(
  bbc_in_if.sink chars,
  output cmd_t   cmd,
  output logic   cmd_valid,
  input  logic   cmd_ready
);

  assign chars.ready = cmd_ready;
  assign cmd_valid   = chars.valid;

  always_comb begin
    cmd.last = chars.last;
    cmd.op   = OP_NONE;
    cmd.kind = KIND_ROUND;
    case (chars.ch)
      CH_LPAREN: begin cmd.op = OP_PUSH; cmd.kind = KIND_ROUND;  end
      CH_LBRACK: begin cmd.op = OP_PUSH; cmd.kind = KIND_SQUARE; end
      CH_LBRACE: begin cmd.op = OP_PUSH; cmd.kind = KIND_CURLY;  end
      CH_RPAREN: begin cmd.op = OP_POP;  cmd.kind = KIND_ROUND;  end
      CH_RBRACK: begin cmd.op = OP_POP;  cmd.kind = KIND_SQUARE; end
      CH_RBRACE: begin cmd.op = OP_POP;  cmd.kind = KIND_CURLY;  end
      default: begin
        cmd.op   = OP_NONE;
        cmd.kind = KIND_ROUND;
      end
    endcase
  end

endmodule

FILE: hdl/bbc_queue.sv
// Short command queue that decouples the front from the stack back end.
// Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_queue
  import bbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t wr_cmd,
  input  logic wr_valid,
  output logic wr_ready,
  output cmd_t rd_cmd,
  output logic rd_valid,
  input  logic rd_ready
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/bbc_back.sv
// Back end: executes stack commands and produces the verdict word.
// Depends on bbc_pkg and bbc_out_if.
`timescale 1ns / 1ps

module bbc_back
  import bbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  bbc_out_if.source  verdict
);

  // The top entry lives in tos; the memory holds the entries below it.
  // rd_data is read ahead and holds the entry under the top, if there is one.
  kind_t              mem [STACK_DEPTH];
  kind_t              tos;
  kind_t              tos_next;
  kind_t              rd_data;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_next;
  logic [LEVEL_W-1:0] level_op;
  logic               mismatch_seen;
  logic               mismatch_next;
  logic               mismatch_op;
  logic               overflow_seen;
  logic               overflow_next;
  logic               overflow_op;
  logic               we;
  logic [ADDR_W-1:0]  wa;
  logic [ADDR_W-1:0]  rd_addr;
  logic               take;
  logic               out_valid;
  logic               out_balanced;
  logic               out_overflow;

  // A verdict-producing command waits only while the output register is held.
  assign cmd_ready = !cmd.last || !out_valid || verdict.ready;
  assign take      = cmd_valid && cmd_ready;

  always_comb begin
    level_op    = level;
    tos_next    = tos;
    mismatch_op = mismatch_seen;
    overflow_op = overflow_seen;
    we          = 1'b0;
    wa          = '0;
    if (take) begin
      case (cmd.op)
        OP_PUSH: begin
          if (level == LEVEL_W'(STACK_DEPTH)) begin
            overflow_op = 1'b1;
          end else begin
            if (level != '0) begin
              we = 1'b1;
              wa = ADDR_W'(level - 1'b1);
            end
            tos_next = cmd.kind;
            level_op = level + 1'b1;
          end
        end
        OP_POP: begin
          if (level == '0) begin
            mismatch_op = 1'b1;
          end else begin
            if (tos != cmd.kind) begin
              mismatch_op = 1'b1;
            end
            tos_next = rd_data;
            level_op = level - 1'b1;
          end
        end
        default: begin
          level_op = level;
        end
      endcase
    end
    if (take && cmd.last) begin
      level_next    = '0;
      mismatch_next = 1'b0;
      overflow_next = 1'b0;
    end else begin
      level_next    = level_op;
      mismatch_next = mismatch_op;
      overflow_next = overflow_op;
    end
    rd_addr = ADDR_W'(level_next - LEVEL_W'(2));
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= tos;
    end
    rd_data <= (we && wa == rd_addr) ? tos : mem[rd_addr];
    tos     <= tos_next;
    if (take && cmd.last) begin
      out_balanced <= !mismatch_op && !overflow_op && (level_op == '0);
      out_overflow <= overflow_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= '0;
      mismatch_seen <= 1'b0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      level         <= level_next;
      mismatch_seen <= mismatch_next;
      overflow_seen <= overflow_next;
      if (take && cmd.last) begin
        out_valid <= 1'b1;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign verdict.valid    = out_valid;
  assign verdict.balanced = out_balanced;
  assign verdict.overflow = out_overflow;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && cmd.last |=> level == '0 && !mismatch_seen && !overflow_seen)
    else $error("state not cleared after final word");

  a_pop_level: assert property (@(posedge clk) disable iff (rst)
    take && !cmd.last && cmd.op == OP_POP && level != '0 |=> level == $past(level) - 1'b1)
    else $error("pop did not lower the level");

  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(take && cmd.last))
    else $error("verdict without a final word");

endmodule

FILE: hdl/bracket_balance_checker_top.sv
// Top level of the bracket balance checker.
// Depends on bbc_pkg, bbc_if, bbc_front, bbc_queue and bbc_back.
`timescale 1ns / 1ps

// The block takes one character word per clock cycle on chars while the queue
// has room. For the word marked last, it gives one verdict word on verdict;
// words without last give no result. The final word is registered in the queue
// and its verdict in the output register before it is offered. Characters
// pass through a classifier and a two-entry command queue into the stack unit,
// which keeps the top entry and the entry under it in registers so that a
// push or pop of the 64-entry stack completes every cycle. Only a held verdict
// stalls the stack unit, and then only when the next command is itself a final
// one. Nesting deeper than the stack reports overflow and an unbalanced
// verdict. All state clears after each verdict; no clearing pass follows reset.
module bracket_balance_checker_top
  import bbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bbc_in_if.sink    chars,
  bbc_out_if.source verdict
);

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  bbc_front u_front (
    .chars     (chars),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  bbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_cmd   (front_cmd),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_cmd   (back_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  bbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .verdict   (verdict)
  );

endmodule

FILE: tb/sv/bbc_verdict_checker.sv
// Verdict checker for the bracket balance checker: predicts and compares verdicts.
// Depends on bbc_pkg and the channel interfaces in bbc_if.
`timescale 1ns / 1ps

module bbc_verdict_checker
  import bbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bbc_in_if    chars,
  bbc_out_if   verdict,
  output int   fails,
  output int   pending
);

  typedef struct packed {
    logic balanced;
    logic overflow;
  } verdict_t;

  kind_t    open_kinds [STACK_DEPTH];
  int       nest_level;
  logic     mismatch_flag;
  logic     overflow_flag;
  verdict_t expected_verdicts [$];
  int       verdicts_seen;

  function automatic op_t bracket_op(input logic [7:0] c);
    case (c)
      CH_LPAREN, CH_LBRACK, CH_LBRACE: return OP_PUSH;
      CH_RPAREN, CH_RBRACK, CH_RBRACE: return OP_POP;
      default: return OP_NONE;
    endcase
  endfunction

  function automatic kind_t bracket_kind(input logic [7:0] c);
    case (c)
      CH_LBRACK, CH_RBRACK: return KIND_SQUARE;
      CH_LBRACE, CH_RBRACE: return KIND_CURLY;
      default: return KIND_ROUND;
    endcase
  endfunction

  task automatic clear_expression();
    nest_level    = 0;
    mismatch_flag = 1'b0;
    overflow_flag = 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns checker: verdict %0d: %s", $time, verdicts_seen, msg);
    fails++;
  endtask

  // Advances the expression state by one character word and queues the
  // verdict that a final word calls for.
  task automatic predict_char(input logic [7:0] c, input logic is_last);
    verdict_t v;
    kind_t    k;
    k = bracket_kind(c);
    case (bracket_op(c))
      OP_PUSH: begin
        if (nest_level >= STACK_DEPTH) begin
          overflow_flag = 1'b1;
        end else begin
          open_kinds[nest_level] = k;
          nest_level++;
        end
      end
      OP_POP: begin
        if (nest_level == 0) begin
          mismatch_flag = 1'b1;
        end else begin
          nest_level--;
          if (open_kinds[nest_level] != k) mismatch_flag = 1'b1;
        end
      end
      default: ;
    endcase
    if (is_last) begin
      v.balanced = !mismatch_flag && !overflow_flag && (nest_level == 0);
      v.overflow = overflow_flag;
      expected_verdicts.push_back(v);
      clear_expression();
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      clear_expression();
      expected_verdicts.delete();
      fails         = 0;
      verdicts_seen = 0;
    end else begin
      if (verdict.valid && verdict.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict word arrived with none expected");
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict.balanced !== want.balanced)
            report_mismatch($sformatf("balanced got %b want %b",
                                      verdict.balanced, want.balanced));
          if (verdict.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %b want %b",
                                      verdict.overflow, want.overflow));
        end
        verdicts_seen++;
      end
      if (chars.valid && chars.ready) predict_char(chars.ch, chars.last);
    end
    pending <= expected_verdicts.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the bracket balance checker testbench: clock, reset, stimulus and verdict.
// Depends on bbc_pkg, bbc_if, bracket_balance_checker_top and bbc_verdict_checker.
`timescale 1ns / 1ps

module testbench;
  import bbc_pkg::*;

  localparam int         HOLD_CYCLES = 200;
  localparam int         TAIL_CYCLES = 20;
  localparam int         PHASE_CHARS = 150;
  localparam logic [7:0] CH_LETTER_A = 8'h61;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_requests;
  int   holds_done;

  logic [7:0] expr_chars [$];

  bbc_in_if  chars_if ();
  bbc_out_if verdict_if ();

  bracket_balance_checker_top u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .verdict (verdict_if)
  );

  bbc_verdict_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .verdict (verdict_if),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #400000;
    $display("testbench: FAIL");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    verdict_if.ready = 1'b0;
    holds_done       = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        verdict_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        verdict_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] open_char(input kind_t k);
    case (k)
      KIND_SQUARE: return CH_LBRACK;
      KIND_CURLY:  return CH_LBRACE;
      default:     return CH_LPAREN;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input kind_t k);
    case (k)
      KIND_SQUARE: return CH_RBRACK;
      KIND_CURLY:  return CH_RBRACE;
      default:     return CH_RPAREN;
    endcase
  endfunction

  function automatic logic [7:0] filler_char();
    return CH_LETTER_A + 8'($urandom_range(25));
  endfunction

  task automatic send_word(input logic [7:0] c, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch    <= c;
    chars_if.last  <= is_last;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_chars.size(); i++)
      send_word(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  // Stops offering words and waits until every verdict has come back.
  task automatic wait_drained();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Properly nested expression with random kinds and letters in between.
  task automatic build_nested(input int max_depth, input int steps);
    kind_t stack_kinds [$];
    kind_t k;
    int    r;
    expr_chars.delete();
    repeat (steps) begin
      r = $urandom_range(99);
      if (r < 45 && stack_kinds.size() < max_depth) begin
        k = kind_t'($urandom_range(2));
        stack_kinds.push_back(k);
        expr_chars.push_back(open_char(k));
      end else if (r < 85 && stack_kinds.size() > 0) begin
        expr_chars.push_back(close_char(stack_kinds.pop_back()));
      end else begin
        expr_chars.push_back(filler_char());
      end
    end
    while (stack_kinds.size() > 0) expr_chars.push_back(close_char(stack_kinds.pop_back()));
    if (expr_chars.size() == 0) expr_chars.push_back(filler_char());
  endtask

  // Nesting straight down to the given depth and back out again.
  task automatic build_deep(input int depth);
    kind_t stack_kinds [$];
    kind_t k;
    expr_chars.delete();
    repeat (depth) begin
      k = kind_t'($urandom_range(2));
      stack_kinds.push_back(k);
      expr_chars.push_back(open_char(k));
      if ($urandom_range(9) == 0) expr_chars.push_back(filler_char());
    end
    while (stack_kinds.size() > 0) expr_chars.push_back(close_char(stack_kinds.pop_back()));
  endtask

  initial begin
    int    sent;
    int    r;
    int    idx;
    kind_t k;

    rst            = 1'b1;
    chars_if.valid = 1'b0;
    chars_if.ch    = 8'h00;
    chars_if.last  = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_requests  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each kind matched and nested, a kind mismatch, a crossed pair, a close
    // on an empty stack, an unclosed open, byte extremes and a close before its open.
    expr_chars = '{CH_LPAREN, CH_RPAREN};
    send_expr();
    expr_chars = '{CH_LBRACK, CH_RBRACK};
    send_expr();
    expr_chars = '{CH_LBRACE, CH_RBRACE};
    send_expr();
    expr_chars = '{CH_LPAREN, CH_RBRACK};
    send_expr();
    expr_chars = '{CH_RPAREN};
    send_expr();
    expr_chars = '{8'h00};
    send_expr();
    expr_chars = '{8'hFF};
    send_expr();
    expr_chars = '{CH_LPAREN, CH_LBRACK, CH_RPAREN, CH_RBRACK};
    send_expr();
    expr_chars = '{CH_LPAREN};
    send_expr();
    expr_chars = '{CH_RBRACE, CH_LBRACE};
    send_expr();
    expr_chars = '{CH_LBRACE, CH_LBRACK, CH_LPAREN, CH_RPAREN, CH_RBRACK, CH_RBRACE};
    send_expr();
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      // A stack filled exactly, then one open too many, then around the edge.
      if (phase == 0) build_deep(STACK_DEPTH);
      else if (phase == 1) build_deep(STACK_DEPTH + 1);
      else build_deep($urandom_range(STACK_DEPTH + 4, STACK_DEPTH - 4));
      send_expr();

      // With the receiver held off, a run of one-word expressions backs the
      // block up until it stalls its input.
      if (phase == 2) begin
        hold_requests++;
        repeat (24) begin
          expr_chars = '{8'($urandom_range(255))};
          send_expr();
        end
        wait_drained();
      end

      sent = 0;
      while (sent < PHASE_CHARS) begin
        r = $urandom_range(99);
        if (r < 65) begin
          build_nested($urandom_range(6, 1), $urandom_range(14, 1));
        end else if (r < 85) begin
          build_nested($urandom_range(6, 1), $urandom_range(14, 2));
          idx = $urandom_range(expr_chars.size() - 1);
          k   = kind_t'($urandom_range(2));
          case ($urandom_range(2))
            0: expr_chars[idx] = open_char(k);
            1: expr_chars[idx] = close_char(k);
            default: if (expr_chars.size() > 1) expr_chars.delete(idx);
          endcase
        end else begin
          expr_chars.delete();
          repeat ($urandom_range(12, 1)) begin
            if ($urandom_range(3) == 0) begin
              k = kind_t'($urandom_range(2));
              expr_chars.push_back($urandom_range(1) ? open_char(k) : close_char(k));
            end else begin
              expr_chars.push_back(8'($urandom_range(255)));
            end
          end
        end
        sent += expr_chars.size();
        send_expr();
        if ($urandom_range(9) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: bracket_balance_checker_top.f
hdl/bbc_pkg.sv
hdl/bbc_if.sv
hdl/bbc_front.sv
hdl/bbc_queue.sv
hdl/bbc_back.sv
hdl/bracket_balance_checker_top.sv
tb/sv/bbc_verdict_checker.sv
tb/sv/testbench.sv
